[hdl/bec_pkg.sv]
// Shared constants, types and log2 helpers for the byte entropy classifier.
package bec_pkg;

  localparam int MAX_LEN   = 16384;
  localparam int BINS      = 256;
  localparam int CNT_W     = 15;
  localparam int LOG_W     = 16;
  localparam int LT_W      = 13;
  localparam int SUM_W     = 31;
  localparam int REM_W     = CNT_W + 1;
  localparam int H_W       = 16;
  localparam int DIV_CNT_W = 5;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CNT_W-1:0] MAX_LEN_C = CNT_W'(MAX_LEN);
  localparam logic [H_W-1:0]   H_MAX     = 16'd32768;
  localparam logic [H_W-1:0]   THR_RESET = 16'd20480;

  // Register select is the word index taken from the byte address.
  localparam logic REG_THRESHOLD = 1'b0;

  typedef logic [LT_W-1:0] log_tab_t [BINS];

  function automatic log_tab_t build_log_tab();
    log_tab_t   tab;
    logic [63:0] x;
    logic [31:0] v;
    for (int m = 0; m < BINS; m++) begin
      x = 64'h4000_0000 + (64'(m) << 22);
      v = '0;
      for (int k = 0; k < 13; k++) begin
        x = (x * x) >> 30;
        v = v << 1;
        if (x >= 64'h8000_0000) begin
          v = v | 32'd1;
          x = x >> 1;
        end
      end
      tab[m] = LT_W'((v + 32'd1) >> 1);
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  // log2 in Q.12: leading-one position plus a fraction from the next 8 bits.
  function automatic logic [LOG_W-1:0] log2q(input logic [CNT_W-1:0] x);
    logic [3:0]         p;
    logic [CNT_W+7:0]   sh;
    logic [7:0]         m;
    p = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (x[i]) p = 4'(i);
    end
    sh = {x, 8'h00} >> p;
    m  = sh[7:0];
    return {p, 12'h000} + LOG_W'(LOG_TAB[m]);
  endfunction

  typedef struct packed {
    logic             in_ready;
    logic             inc;
    logic             sweep_rd;
    logic [7:0]       sweep_addr;
    logic             div_start;
    logic             load_out;
    logic             clear;
  } bec_cmd_t;

  typedef struct packed {
    logic accepted;
    logic last;
    logic pipe_busy;
    logic div_done;
    logic out_free;
  } bec_status_t;

endpackage

[hdl/bec_if.sv]
// Handshake interfaces for the byte input channel and the result channel.
interface bec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] entropy;
  logic        is_encrypted;
  logic [14:0] payload_length;
  modport source (output valid, output entropy, output is_encrypted,
                  output payload_length, input ready);
  modport sink   (input valid, input entropy, input is_encrypted,
                  input payload_length, output ready);
endinterface

[hdl/bec_div.sv]
// Restoring divider, one quotient bit per cycle.
module bec_div
  import bec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output logic             done
);

  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  always_comb begin
    trial    = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = DIV_CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - {1'b0, divisor}) : trial;
      quo_nxt = {quo_r[SUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[hdl/bec_dp.sv]
// Datapath: histogram memory, byte count, c*log2(c) pipeline, divider, result register.
module bec_dp
  import bec_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  bec_cmd_t       cmd,
  output bec_status_t    status,
  input  logic [H_W-1:0] threshold,
  bec_in_if.sink         in_ch,
  bec_out_if.source      out_ch
);

  logic [CNT_W-1:0] hist_mem [BINS];
  logic [BINS-1:0]  vbits_r;
  logic [CNT_W-1:0] rd_q;
  logic             vld_q;
  logic [7:0]       rd_addr;
  logic [7:0]       byte_r;
  logic             cnt_en_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] cur_c;
  logic             wr_en;

  logic             s1_v_r, s2_v_r, s3_v_r;
  logic [CNT_W-1:0] c2_r;
  logic [LOG_W-1:0] lg2_r;
  logic [SUM_W-1:0] prod_r;
  logic [SUM_W-1:0] sum_r;
  logic [LOG_W-1:0] ln_r;

  logic [SUM_W-1:0] quo;
  logic             div_done;
  logic [H_W-1:0]   h;
  logic [LOG_W-1:0] diff;

  logic             out_v_r;
  logic [H_W-1:0]   out_h_r;
  logic             out_enc_r;
  logic [CNT_W-1:0] out_len_r;

  assign in_ch.ready = cmd.in_ready;
  assign rd_addr     = cmd.sweep_rd ? cmd.sweep_addr : in_ch.data_byte;
  assign cur_c       = vld_q ? rd_q : '0;
  assign wr_en       = cmd.inc && cnt_en_r;

  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[byte_r] <= cur_c + 1'b1;
    rd_q  <= hist_mem[rd_addr];
    vld_q <= vbits_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vbits_r <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      if (wr_en) begin
        vbits_r[byte_r] <= 1'b1;
        count_r         <= count_r + 1'b1;
      end
      if (s3_v_r) sum_r <= sum_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (status.accepted) begin
      byte_r   <= in_ch.data_byte;
      cnt_en_r <= count_r != MAX_LEN_C;
    end
    c2_r   <= cur_c;
    lg2_r  <= log2q(cur_c);
    prod_r <= c2_r * lg2_r;
    ln_r   <= log2q(count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.sweep_rd;
      s2_v_r <= s1_v_r && (cur_c != '0);
      s3_v_r <= s2_v_r;
    end
  end

  bec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    diff = ln_r - quo[LOG_W-1:0];
    if (quo >= SUM_W'(ln_r))  h = '0;
    else if (diff > H_MAX)    h = H_MAX;
    else                      h = diff;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_h_r   <= h;
      out_enc_r <= h >= threshold;
      out_len_r <= count_r;
    end
    if (!rst_n) out_v_r <= 1'b0;
    else if (cmd.load_out) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.entropy        = out_h_r;
  assign out_ch.is_encrypted   = out_enc_r;
  assign out_ch.payload_length = out_len_r;

  assign status.accepted  = in_ch.valid && cmd.in_ready;
  assign status.last      = in_ch.last_byte;
  assign status.pipe_busy = s1_v_r || s2_v_r || s3_v_r;
  assign status.div_done  = div_done;
  assign status.out_free  = !out_v_r || out_ch.ready;

endmodule

[hdl/bec_ctrl.sv]
// Controller: sequences byte updates, the bin sweep, the division and the result load.
module bec_ctrl
  import bec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  bec_status_t status,
  output bec_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INC   = 6'b000010,
    S_SWEEP = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic       last_r, last_nxt;
  logic [7:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.accepted) begin
          last_nxt  = status.last;
          state_nxt = S_INC;
        end
      end
      S_INC: begin
        cmd.inc   = 1'b1;
        idx_nxt   = '0;
        state_nxt = last_r ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        cmd.sweep_rd   = 1'b1;
        cmd.sweep_addr = idx_r;
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == 8'hFF) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[hdl/byte_entropy_classifier.sv]
// Top level of the byte entropy classifier: configuration register and unit wiring.
//
//   Channel  Direction  Carries
//   in_ch    sink       data_byte, last_byte: one payload byte per beat
//   out_ch   source     entropy, is_encrypted, payload_length: one beat per packet
//   APB      slave      encrypt_threshold at byte address 0
//
// Each payload byte reads its histogram bin in the idle state, from the bin
// memory with one read and one write port, and writes the incremented count
// back in the increment state; the next byte is accepted only after that.
// The final byte additionally costs a sweep over the 256 bins, a drain of
// the pipeline, the bit-serial divider (31 quotient bits and the done flag)
// and the load of the result register.
// Reset is synchronous and active low; the histogram is emptied at once
// through per-bin valid flags, both at reset and after each result.
// A stalled result sink holds the controller in its final state until the
// result register frees up; no input beat is accepted meanwhile.
module byte_entropy_classifier
  import bec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bec_in_if.sink            in_ch,
  bec_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [H_W-1:0] threshold_r;
  bec_cmd_t       cmd;
  bec_status_t    status;

  // The APB port never waits; the threshold is written in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) begin
      threshold_r <= pwdata[H_W-1:0];
    end
  end

  // Only the threshold register exists; addresses with paddr[2] set read as zero.
  assign prdata = (paddr[2] == REG_THRESHOLD) ? DATA_W'(threshold_r) : '0;

  bec_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  bec_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .threshold (threshold_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

[tb/sv/byte_entropy_classifier_test.sv]
// Self-checking testbench for the byte entropy classifier: directed, threshold and random tests.
module byte_entropy_classifier_test;
  import bec_pkg::*;

  typedef struct {
    logic [15:0] entropy;
    logic        is_encrypted;
    logic [14:0] payload_length;
  } entropy_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bec_in_if  in_ch ();
  bec_out_if out_ch ();

  byte_entropy_classifier dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Predictor state: our own histogram, byte count and threshold copy.
  int unsigned     bin_count [256];
  int unsigned     bytes_seen;
  logic [15:0]     threshold_q;
  logic [12:0]     frac_tab [256];
  entropy_result_t pending_results [$];
  int              failures = 0;
  int              idle_cycles = 0;
  int              out_stall = 0;
  bit              allow_gaps = 1'b1;

  // Fraction table of log2(1 + m/256): square-and-compare to 13 bits, then round.
  task automatic fill_frac_tab();
    logic [63:0] mant;
    logic [31:0] bits;
    for (int m = 0; m < 256; m++) begin
      mant = 64'h4000_0000 + (64'(m) << 22);
      bits = '0;
      for (int k = 0; k < 13; k++) begin
        mant = (mant * mant) >> 30;
        bits = bits << 1;
        if (mant >= 64'h8000_0000) begin
          bits = bits | 32'd1;
          mant = mant >> 1;
        end
      end
      frac_tab[m] = 13'((bits + 32'd1) >> 1);
    end
  endtask

  function automatic longint unsigned fixed_log2(input int unsigned x);
    int unsigned lead;
    int unsigned mbits;
    lead = 0;
    if (x == 0) return 0;
    while (lead < 31 && (x >> (lead + 1)) != 0) lead++;
    if (lead >= 8) mbits = (x >> (lead - 8)) & 255;
    else mbits = (x << (8 - lead)) & 255;
    return lead * 4096 + frac_tab[mbits];
  endfunction

  // Counts one byte; on the final byte of a packet it queues the expected result.
  task automatic predict_entropy(input logic [7:0] b, input logic last);
    longint unsigned weighted;
    longint unsigned mean_term;
    longint unsigned log_n;
    longint unsigned h;
    entropy_result_t r;
    weighted = 0;
    if (bytes_seen < MAX_LEN) begin
      bin_count[b]++;
      bytes_seen++;
    end
    if (!last) return;
    for (int i = 0; i < 256; i++)
      if (bin_count[i] != 0) weighted += longint'(bin_count[i]) * fixed_log2(bin_count[i]);
    mean_term = weighted / bytes_seen;
    log_n = fixed_log2(bytes_seen);
    if (mean_term >= log_n) h = 0;
    else if (log_n - mean_term > 32768) h = 32768;
    else h = log_n - mean_term;
    r.entropy = 16'(h);
    r.is_encrypted = (16'(h) >= threshold_q);
    r.payload_length = 15'(bytes_seen);
    pending_results.push_back(r);
    foreach (bin_count[i]) bin_count[i] = 0;
    bytes_seen = 0;
  endtask

  // Sends one byte beat, with an occasional random gap before it. Valid stays
  // high after the beat, so the next byte can follow at once; callers drop it
  // when traffic pauses.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_entropy(b, last);
  endtask

  task automatic send_packet(input int len, input int alphabet);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, alphabet - 1)), i == len - 1);
  endtask

  // Waits for all results, plus the drain time of the block, before a register write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(REG_THRESHOLD) << 2;
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    threshold_q = value;
  endtask

  // Result side: random stall bursts, and a check of each beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no packet outstanding");
          failures++;
        end else begin
          entropy_result_t e;
          e = pending_results.pop_front();
          if (out_ch.entropy !== e.entropy) begin
            $error("entropy expected %0d got %0d", e.entropy, out_ch.entropy);
            failures++;
          end
          if (out_ch.is_encrypted !== e.is_encrypted) begin
            $error("is_encrypted expected %0d got %0d", e.is_encrypted, out_ch.is_encrypted);
            failures++;
          end
          if (out_ch.payload_length !== e.payload_length) begin
            $error("payload_length expected %0d got %0d", e.payload_length,
                   out_ch.payload_length);
            failures++;
          end
        end
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        out_stall <= $urandom_range(0, 8);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted beat; a maximal packet sweep plus stalls fits easily.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[byte_entropy_classifier] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'(1 << i), i == 7);
    for (int i = 0; i < 4; i++) send_byte(8'hAA, i == 3);
    send_packet(6, 2);
  endtask

  // Every byte value once: entropy reaches exactly 8.0, the saturation ceiling.
  task automatic test_full_alphabet();
    for (int i = 0; i < 256; i++) send_byte(8'(i), i == 255);
  endtask

  task automatic test_thresholds();
    drain();
    write_threshold(16'd0);
    send_packet(3, 1);
    drain();
    write_threshold(16'd32768);
    test_full_alphabet();
    drain();
    write_threshold(16'hFFFF);
    send_packet(20, 256);
    drain();
    write_threshold(16'd12288);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 1450) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      if (sent > 1200) allow_gaps = 1'b0;
      send_packet(len, $urandom_range(1, 256));
      sent += len;
    end
  endtask

  initial begin
    fill_frac_tab();
    foreach (bin_count[i]) bin_count[i] = 0;
    bytes_seen = 0;
    threshold_q = THR_RESET;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_alphabet();
    test_thresholds();
    test_random();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (failures == 0) $display("[byte_entropy_classifier] OK");
    else $display("[byte_entropy_classifier] ERROR");
    $finish;
  end
endmodule
